>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers used by the address generator top level.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property holds at every clock edge outside reset.
`define TPAG_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Expression is never true at a clock edge outside reset.
`define TPAG_NEVER(label, clk, rstn, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define TPAG_ASSERT(label, clk, rstn, prop, msg)
`define TPAG_NEVER(label, clk, rstn, expr, msg)

`endif

`endif

>>> hdl/tpag_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tensor permute address generator package
// Shared constants, register codes and the geometry bundle.
// ----------------------------------------------------------------------------
package tpag_pkg;

  // Tensor rank and index width.
  localparam int unsigned NUM_AXES = 4;
  localparam int unsigned IDX_W    = 32;

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  // Register reset values: unit dimensions and the identity permutation.
  localparam logic [CFG_DATA_W-1:0] DIM_RESET  = 8'd1;
  localparam logic [CFG_DATA_W-1:0] PERM_RESET = 8'd228;

  // Cycles for the stride and step tables to settle after a restart.
  localparam int unsigned SETTLE_W = 3;
  localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 3'd5;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIM_BATCH   = 3'd0,
    REG_DIM_CHANNEL = 3'd1,
    REG_DIM_HEIGHT  = 3'd2,
    REG_DIM_WIDTH   = 3'd3,
    REG_PERM_CODE   = 3'd4
  } tpag_reg_e;

  // Geometry handed from the stride calculator to the walker.
  typedef struct packed {
    logic [NUM_AXES-1:0][CFG_DATA_W-1:0] dim_m1;  // effective size minus one
    logic [NUM_AXES-1:0][IDX_W-1:0]      delta;   // destination step per axis
  } tpag_geom_t;

endpackage

>>> hdl/tpag_stride_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stride calculator
// Holds the configuration registers and derives, over a short pipeline, the
// destination step applied when each source axis advances.
// ----------------------------------------------------------------------------
module tpag_stride_calc import tpag_pkg::*; #(
  parameter int unsigned DIM_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output tpag_geom_t            geom_o,
  output logic                  busy_o,
  output logic                  restart_o
);

  // Only the low bits of a dimension count when the counters are narrow.
  localparam int unsigned EFF_W = (DIM_BITS < CFG_DATA_W) ? DIM_BITS : CFG_DATA_W;

  logic [NUM_AXES-1:0][CFG_DATA_W-1:0] dim_q;
  logic [CFG_DATA_W-1:0]               perm_q;
  logic [SETTLE_W-1:0]                 settle_q;

  logic [NUM_AXES-1:0][CFG_DATA_W-1:0] dim_raw;
  logic [NUM_AXES-1:0][CFG_DATA_W-1:0] dim_eff;
  logic [NUM_AXES-1:0][CFG_DATA_W-1:0] dim_m1;
  logic [NUM_AXES-1:0][1:0]            perm_sel;
  logic [NUM_AXES-1:0][CFG_DATA_W-1:0] dim_p;

  logic [2*CFG_DATA_W-1:0]             prod1_q;
  logic [NUM_AXES-1:0][3*CFG_DATA_W-1:0] stride_q;
  logic [NUM_AXES-1:0][IDX_W-1:0]      sstride_d, sstride_q;
  logic [NUM_AXES-1:0][IDX_W-1:0]      wrap_q;
  logic [NUM_AXES-1:0][IDX_W-1:0]      delta_d, delta_q;

  // A write to a known register restarts the stream.
  assign restart_o = cfg_we_i && (cfg_idx_i <= REG_PERM_CODE);
  assign busy_o    = (settle_q != '0);

  // Configuration registers and the settle counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q    <= {NUM_AXES{DIM_RESET}};
      perm_q   <= PERM_RESET;
      settle_q <= SETTLE_CYCLES;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_DIM_BATCH:   dim_q[0] <= cfg_wdata_i;
          REG_DIM_CHANNEL: dim_q[1] <= cfg_wdata_i;
          REG_DIM_HEIGHT:  dim_q[2] <= cfg_wdata_i;
          REG_DIM_WIDTH:   dim_q[3] <= cfg_wdata_i;
          REG_PERM_CODE:   perm_q   <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (restart_o) begin
        settle_q <= SETTLE_CYCLES;
      end else if (settle_q != '0) begin
        settle_q <= settle_q - 1'b1;
      end
    end
  end

  // Effective sizes: a zero size counts as one; the permuted shape.
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      dim_raw[a]  = CFG_DATA_W'(dim_q[a][EFF_W-1:0]);
      dim_eff[a]  = (dim_raw[a] == '0) ? CFG_DATA_W'(1) : dim_raw[a];
      dim_m1[a]   = dim_eff[a] - 1'b1;
      perm_sel[a] = perm_q[2*a +: 2];
    end
    for (int i = 0; i < NUM_AXES; i++) begin
      dim_p[i] = dim_eff[perm_sel[i]];
    end
  end

  // Per source axis, the sum of the output strides it feeds.
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      sstride_d[a] = '0;
      for (int i = 0; i < NUM_AXES; i++) begin
        if (perm_sel[i] == 2'(a)) begin
          sstride_d[a] = sstride_d[a] + IDX_W'(stride_q[i]);
        end
      end
    end
  end

  // Step for an advance of axis j: its own stride less the rewind of all
  // faster axes, which wrap back to zero at the same time.
  always_comb begin
    logic [IDX_W-1:0] tail;
    tail = '0;
    for (int j = NUM_AXES - 1; j >= 0; j--) begin
      delta_d[j] = sstride_q[j] - tail;
      tail       = tail + wrap_q[j];
    end
  end

  // Stride and step pipeline, one multiplication per stage.
  always_ff @(posedge clk_i) begin
    prod1_q     <= (2*CFG_DATA_W)'(dim_p[3]) * (2*CFG_DATA_W)'(dim_p[2]);
    stride_q[3] <= (3*CFG_DATA_W)'(1);
    stride_q[2] <= (3*CFG_DATA_W)'(dim_p[3]);
    stride_q[1] <= (3*CFG_DATA_W)'(prod1_q);
    stride_q[0] <= (3*CFG_DATA_W)'(prod1_q) * (3*CFG_DATA_W)'(dim_p[1]);
    sstride_q   <= sstride_d;
    for (int a = 0; a < NUM_AXES; a++) begin
      wrap_q[a] <= IDX_W'(dim_m1[a]) * sstride_q[a];
    end
    delta_q     <= delta_d;
  end

  assign geom_o.dim_m1 = dim_m1;
  assign geom_o.delta  = delta_q;

endmodule

>>> hdl/tpag_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coordinate walker
// Steps the NCHW coordinate counters in source order and keeps the running
// source and destination indices.
// ----------------------------------------------------------------------------
module tpag_walker import tpag_pkg::*; #(
  parameter int unsigned DIM_BITS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             restart_i,
  input  tpag_geom_t       geom_i,
  output logic [IDX_W-1:0] src_index_o,
  output logic [IDX_W-1:0] dst_index_o,
  output logic             last_o
);

  localparam int unsigned CMP_W = (DIM_BITS > CFG_DATA_W) ? DIM_BITS : CFG_DATA_W;

  logic [NUM_AXES-1:0][DIM_BITS-1:0] cnt_d, cnt_q;
  logic [IDX_W-1:0]                  src_d, src_q;
  logic [IDX_W-1:0]                  dst_d, dst_q;
  logic [NUM_AXES-1:0]               at_end;
  logic [IDX_W-1:0]                  delta_sel;

  // An axis wraps when its counter sits on the last coordinate.
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      at_end[a] = (CMP_W'(cnt_q[a]) == CMP_W'(geom_i.dim_m1[a]));
    end
  end

  assign last_o = &at_end;

  // Ripple the carry from the width axis towards the batch axis.
  always_comb begin
    logic carry;
    carry = 1'b1;
    for (int a = NUM_AXES - 1; a >= 0; a--) begin
      cnt_d[a] = cnt_q[a];
      if (carry) begin
        if (at_end[a]) begin
          cnt_d[a] = '0;
        end else begin
          cnt_d[a] = cnt_q[a] + 1'b1;
          carry    = 1'b0;
        end
      end
    end
  end

  // Destination step of the slowest axis that advances.
  always_comb begin
    priority if (!at_end[3]) begin
      delta_sel = geom_i.delta[3];
    end else if (!at_end[2]) begin
      delta_sel = geom_i.delta[2];
    end else if (!at_end[1]) begin
      delta_sel = geom_i.delta[1];
    end else begin
      delta_sel = geom_i.delta[0];
    end
  end

  // Running indices: back to zero after the final element.
  always_comb begin
    if (last_o) begin
      src_d = '0;
      dst_d = '0;
    end else begin
      src_d = src_q + 1'b1;
      dst_d = dst_q + delta_sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      src_q <= '0;
      dst_q <= '0;
    end else if (restart_i) begin
      cnt_q <= '0;
      src_q <= '0;
      dst_q <= '0;
    end else if (step_i) begin
      cnt_q <= cnt_d;
      src_q <= src_d;
      dst_q <= dst_d;
    end
  end

  assign src_index_o = src_q;
  assign dst_index_o = dst_q;

endmodule

>>> hdl/tensor_permute_address_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tensor permute address generator
// Streams NCHW elements and tags each with its source and permuted index.
// ----------------------------------------------------------------------------
// Usage:
//   Elements enter on the input channel (in_valid_i, in_stall_o,
//   elem_value_i) in row-major NCHW order. Each transfer yields one result on
//   the output channel: the element bits, the source index, the index in the
//   permuted tensor and a flag on the final element, after which the stream
//   wraps to the start of the tensor.
//   Each result appears in the cycle after its transfer; throughput is one
//   element per cycle when not stalled, set by a single add of a precomputed
//   step onto the running destination index in the coordinate walker.
//   The result register lets a new element in while the previous result is
//   taken in the same cycle; while the receiver stalls with a result held,
//   the input stalls and the result holds.
//   Reset and every write to a known register restart the stream at element
//   zero; the input then stalls while the stride and step pipeline settles.
//   The user makes writes only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tensor_permute_address_gen import tpag_pkg::*; #(
  parameter int unsigned DIM_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [IDX_W-1:0]      elem_value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [IDX_W-1:0]      out_value_o,
  output logic [IDX_W-1:0]      src_index_o,
  output logic [IDX_W-1:0]      dst_index_o,
  output logic                  last_elem_o
);

  tpag_geom_t       geom;
  logic             busy;
  logic             restart;
  logic             in_acc;
  logic             out_free;
  logic [IDX_W-1:0] src_cur;
  logic [IDX_W-1:0] dst_cur;
  logic             last_cur;

  logic             out_valid_q;
  logic [IDX_W-1:0] out_value_q;
  logic [IDX_W-1:0] src_index_q;
  logic [IDX_W-1:0] dst_index_q;
  logic             last_elem_q;

  // Configuration and derived strides.
  tpag_stride_calc #(
    .DIM_BITS (DIM_BITS)
  ) u_stride_calc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .geom_o      (geom),
    .busy_o      (busy),
    .restart_o   (restart)
  );

  // Coordinate and index tracking.
  tpag_walker #(
    .DIM_BITS (DIM_BITS)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_acc),
    .restart_i   (restart),
    .geom_i      (geom),
    .src_index_o (src_cur),
    .dst_index_o (dst_cur),
    .last_o      (last_cur)
  );

  // Input handshake: take an element when the result register can move on.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = busy || cfg_we_i || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_value_q <= elem_value_i;
      src_index_q <= src_cur;
      dst_index_q <= dst_cur;
      last_elem_q <= last_cur;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign src_index_o = src_index_q;
  assign dst_index_o = dst_index_q;
  assign last_elem_o = last_elem_q;

  // The final element sends the stream back to the start of the tensor.
  `TPAG_ASSERT(a_wrap_to_start, clk_i, rst_ni, (in_acc && last_cur) |=> (src_cur == '0 && dst_cur == '0), "stream did not wrap after the final element")

  // Every other transfer advances the source index by one.
  `TPAG_ASSERT(a_src_advance, clk_i, rst_ni, (in_acc && !last_cur) |=> (src_cur == $past(src_cur) + 1'b1), "source index did not advance by one")

  // A write to a known register restarts the stream and holds off input.
  `TPAG_ASSERT(a_restart, clk_i, rst_ni, restart |=> (src_cur == '0 && dst_cur == '0 && busy), "register write did not restart the stream")

  // No element is taken while the step tables settle.
  `TPAG_NEVER(a_no_take_busy, clk_i, rst_ni, in_acc && busy, "element taken while step tables settle")

endmodule

>>> test/tpag_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tensor permute address generator stream checker
// Follows the register port and both channels. It keeps its own registers,
// coordinate counters and strides, works out the tag of every element that
// enters, and compares each result transfer with the oldest tag waiting.
// ----------------------------------------------------------------------------
module tpag_stream_checker import tpag_pkg::*; #(
  parameter int unsigned DIM_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_o,
  input  logic [IDX_W-1:0]      elem_value_i,
  input  logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  logic [IDX_W-1:0]      out_value_o,
  input  logic [IDX_W-1:0]      src_index_o,
  input  logic [IDX_W-1:0]      dst_index_o,
  input  logic                  last_elem_o,
  output int unsigned           outstanding_o,
  output int unsigned           fail_count_o
);

  // One tagged element as it leaves the block.
  typedef struct packed {
    logic [IDX_W-1:0] value;
    logic [IDX_W-1:0] src;
    logic [IDX_W-1:0] dst;
    logic             last;
  } elem_tag_t;

  localparam logic [31:0] DIM_MASK = (32'd1 << DIM_BITS) - 32'd1;

  logic [CFG_DATA_W-1:0] dim_reg [NUM_AXES];
  logic [CFG_DATA_W-1:0] perm_reg;
  logic [31:0]           coord [NUM_AXES];
  logic [IDX_W-1:0]      src_pos;
  logic [IDX_W-1:0]      stride [NUM_AXES];
  elem_tag_t             expected_tags [$];
  int unsigned           mismatches;

  // Effective size of an axis: cut to the counter width, and a zero reads as one.
  function automatic logic [31:0] axis_size(input int unsigned axis);
    logic [31:0] d;
    d = 32'(dim_reg[axis]) & DIM_MASK;
    return (d == 32'd0) ? 32'd1 : d;
  endfunction

  // Source axis that feeds output axis i.
  function automatic int unsigned source_axis(input int unsigned i);
    return {30'd0, perm_reg[2*i +: 2]};
  endfunction

  // Back to element zero, with the output strides rebuilt from the registers.
  function automatic void restart_stream();
    logic [63:0] prod;
    prod    = 64'd1;
    src_pos = '0;
    for (int i = 0; i < NUM_AXES; i++) coord[i] = '0;
    for (int i = NUM_AXES - 1; i >= 0; i--) begin
      stride[i] = prod[31:0];
      prod      = (prod * 64'(axis_size(source_axis(i)))) & 64'hFFFF_FFFF;
    end
  endfunction

  // Tag the current element, then step the coordinates in row-major order.
  function automatic elem_tag_t tag_element(input logic [IDX_W-1:0] value);
    elem_tag_t   tag;
    logic [63:0] dst;
    logic [31:0] bumped;
    logic        carry;
    dst = '0;
    for (int i = 0; i < NUM_AXES; i++)
      dst += 64'(coord[source_axis(i)]) * 64'(stride[i]);
    tag.value = value;
    tag.src   = src_pos;
    tag.dst   = dst[31:0];
    carry     = 1'b1;
    for (int i = NUM_AXES - 1; i >= 0 && carry; i--) begin
      bumped = coord[i] + 32'd1;
      if (bumped >= axis_size(i)) begin
        coord[i] = '0;
      end else begin
        coord[i] = bumped & DIM_MASK;
        carry    = 1'b0;
      end
    end
    src_pos  = carry ? '0 : src_pos + 1'b1;
    tag.last = carry;
    return tag;
  endfunction

  function automatic void log_fault(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t ns: %s", $time, what);
  endfunction

  // Register writes, result transfers and element transfers, in that order.
  always @(posedge clk_i or negedge rst_ni) begin
    elem_tag_t seen;
    elem_tag_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_AXES; i++) dim_reg[i] = DIM_RESET;
      perm_reg = PERM_RESET;
      restart_stream();
      expected_tags.delete();
      mismatches    = 0;
      outstanding_o <= 0;
      fail_count_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_DIM_BATCH, REG_DIM_CHANNEL, REG_DIM_HEIGHT, REG_DIM_WIDTH: begin
            dim_reg[cfg_idx_i[1:0]] = cfg_wdata_i;
            restart_stream();
          end
          REG_PERM_CODE: begin
            perm_reg = cfg_wdata_i;
            restart_stream();
          end
          // Writes to unused indexes leave everything as it was.
          default: ;
        endcase
      end

      if (out_valid_o && !out_stall_i) begin
        seen.value = out_value_o;
        seen.src   = src_index_o;
        seen.dst   = dst_index_o;
        seen.last  = last_elem_o;
        if (expected_tags.size() == 0) begin
          log_fault($sformatf("result transfer with nothing expected: value %h src %0d dst %0d",
                              seen.value, seen.src, seen.dst));
        end else begin
          want = expected_tags.pop_front();
          if (seen !== want)
            log_fault($sformatf({"result mismatch: expected value %h src %0d dst %0d last %b,",
                                 " got value %h src %0d dst %0d last %b"},
                                want.value, want.src, want.dst, want.last,
                                seen.value, seen.src, seen.dst, seen.last));
        end
      end

      if (in_valid_i && !in_stall_o) expected_tags.push_back(tag_element(elem_value_i));

      outstanding_o <= expected_tags.size();
      fail_count_o  <= mismatches;
    end
  end

endmodule

>>> test/tensor_permute_address_gen_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tensor permute address generator testbench
// Drives element streams through a series of tensor shapes and permutations,
// with random gaps on the input and stalls on the output, and leaves the
// checking of every result transfer to the stream checker beside the block.
// ----------------------------------------------------------------------------
module tensor_permute_address_gen_tb;
  import tpag_pkg::*;

  localparam int unsigned DIM_BITS        = 8;
  localparam int unsigned TOTAL_ELEMS     = 1800;
  localparam int unsigned QUIET_LIMIT     = 1000;
  localparam int unsigned HOLD_OFF_CYCLES = 48;
  localparam int unsigned DRAIN_CYCLES    = 4;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i    = REG_DIM_BATCH;
  logic [CFG_DATA_W-1:0] cfg_wdata_i  = '0;
  logic                  in_valid_i   = 1'b0;
  logic [IDX_W-1:0]      elem_value_i = '0;
  logic                  out_stall_i  = 1'b0;
  logic                  in_stall_o;
  logic                  out_valid_o;
  logic [IDX_W-1:0]      out_value_o;
  logic [IDX_W-1:0]      src_index_o;
  logic [IDX_W-1:0]      dst_index_o;
  logic                  last_elem_o;

  int unsigned outstanding;
  int unsigned fail_count;
  int unsigned quiet_cycles = 0;
  int unsigned elems_sent   = 0;
  int unsigned gap_pct      = 0;
  int unsigned stall_pct    = 0;
  logic        hold_off_req = 1'b0;

  tensor_permute_address_gen #(
    .DIM_BITS(DIM_BITS)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .elem_value_i(elem_value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_value_o (out_value_o),
    .src_index_o (src_index_o),
    .dst_index_o (dst_index_o),
    .last_elem_o (last_elem_o)
  );

  tpag_stream_checker #(
    .DIM_BITS(DIM_BITS)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .elem_value_i (elem_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_value_o  (out_value_o),
    .src_index_o  (src_index_o),
    .dst_index_o  (dst_index_o),
    .last_elem_o  (last_elem_o),
    .outstanding_o(outstanding),
    .fail_count_o (fail_count)
  );

  always #2 clk_i = ~clk_i;

  // Receiver: random stalls, or a long hold-off when one is requested.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Watchdog: too long without any transfer ends the run.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one element, after a random gap, and hold it until the transfer.
  task automatic push_elem(input logic [IDX_W-1:0] value);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    elem_value_i <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    elems_sent++;
  endtask

  // Stop offering and wait until every result has been taken.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  // Once idle, write each known register with the given odds, and maybe an
  // unused index as well.
  task automatic program_tensor(input logic [NUM_AXES-1:0][CFG_DATA_W-1:0] dims,
                                input logic [CFG_DATA_W-1:0] perm,
                                input int unsigned odds, input bit stray);
    wait_idle();
    for (int a = 0; a < NUM_AXES; a++)
      if ($urandom_range(99) < odds) write_reg(CFG_IDX_W'(REG_DIM_BATCH + a), dims[a]);
    if ($urandom_range(99) < odds) write_reg(REG_PERM_CODE, perm);
    if (stray)
      write_reg(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, REG_PERM_CODE + 1)),
                CFG_DATA_W'($urandom()));
    cfg_we_i <= 1'b0;
  endtask

  // Mostly small sizes so that tensors wrap often, with zero and full-scale ones mixed in.
  function automatic logic [CFG_DATA_W-1:0] pick_dim();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 6) return '0;
    if (r < 12) return '1;
    if (r < 18) return CFG_DATA_W'($urandom_range(255));
    return CFG_DATA_W'($urandom_range(4, 1));
  endfunction

  // A true permutation most of the time, otherwise any code, repeats included.
  function automatic logic [CFG_DATA_W-1:0] pick_perm();
    logic [1:0]            order [NUM_AXES];
    logic [1:0]            t;
    int unsigned           j;
    logic [CFG_DATA_W-1:0] code;
    if ($urandom_range(99) < 25) return CFG_DATA_W'($urandom_range(255));
    for (int i = 0; i < NUM_AXES; i++) order[i] = 2'(i);
    for (int i = NUM_AXES - 1; i > 0; i--) begin
      j        = $urandom_range(i);
      t        = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    code = '0;
    for (int i = 0; i < NUM_AXES; i++) code[2*i +: 2] = order[i];
    return code;
  endfunction

  // Stimulus: directed shapes first, then random phases until enough elements.
  initial begin
    int unsigned                         phase;
    int unsigned                         burst;
    logic [NUM_AXES-1:0][CFG_DATA_W-1:0] dims;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset shape: every element is a whole tensor of its own.
    push_elem('0);
    push_elem('1);
    push_elem(32'hAAAA_AAAA);
    push_elem(32'h5555_5555);

    // Reversed axes with a zero batch size; runs once round the tensor and on.
    dims[0] = '0;
    dims[1] = 8'd2;
    dims[2] = 8'd3;
    dims[3] = 8'd2;
    program_tensor(dims, 8'h1B, 100, 1'b1);
    repeat (13) push_elem($urandom());

    // Full-scale axes, all fed from the batch axis, then all from the width axis.
    dims = '1;
    program_tensor(dims, 8'h00, 100, 1'b0);
    repeat (4) push_elem($urandom());
    program_tensor(dims, 8'hFF, 100, 1'b0);
    repeat (2) push_elem($urandom());

    phase = 0;
    while (elems_sent < TOTAL_ELEMS) begin
      for (int a = 0; a < NUM_AXES; a++) dims[a] = pick_dim();
      if ($urandom_range(7) == 0) program_tensor(dims, '0, 0, 1'b1);
      else program_tensor(dims, pick_perm(), 70, $urandom_range(3) == 0);

      case (phase % 4)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 59; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 59; end
        default: begin gap_pct = 18; stall_pct = 18; end
      endcase
      burst = $urandom_range(120, 20);

      // Now and then the receiver holds off while elements keep coming.
      if (phase % 6 == 5) begin
        gap_pct      = 0;
        stall_pct    = 0;
        burst        = 80;
        hold_off_req = 1'b1;
      end

      repeat (burst) push_elem($urandom());
      phase++;
    end

    wait_idle();
    if (fail_count == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
